/* rtl/sha1bs_pkg.sv */
// shared types, codes and constants of the sha-1 byte stream hash unit
// no dependencies; every other file of the block but sha1bs_if imports this package
package sha1bs_pkg;

	// input mode codes
	localparam logic [1:0] MODE_DATA   = 2'd0;
	localparam logic [1:0] MODE_LAST   = 2'd1;
	localparam logic [1:0] MODE_END    = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// operations queued between front and back
	typedef enum logic [1:0] {
		OP_BYTE,
		OP_LAST_BYTE,
		OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} qent_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef logic [15:0][31:0] block_t;
	typedef logic [4:0][31:0]  hash_t;

	localparam hash_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS = 6'h3F;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [6:0] RND_20   = 7'd20;
	localparam logic [6:0] RND_40   = 7'd40;
	localparam logic [6:0] RND_60   = 7'd60;
	localparam logic [6:0] RND_FOLD = 7'd80;

	// back part to compression core
	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

endpackage

/* rtl/sha1bs_if.sv */
// valid/ready channel interfaces of the sha-1 byte stream hash unit
// standalone; widths follow the item fields
interface sha1bs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sha1bs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, digest_word0, digest_word1, digest_word2,
		digest_word3, digest_word4, input ready);
	modport sink (input valid, digest_word0, digest_word1, digest_word2,
		digest_word3, digest_word4, output ready);
endinterface

/* rtl/sha1bs_front.sv */
// front part: takes input items, classifies the mode and holds one op
// depends on sha1bs_pkg and sha1bs_in_if
module sha1bs_front (
	input  logic              clk,
	input  logic              arst_n,
	sha1bs_in_if.sink         msg,
	output sha1bs_pkg::qent_t q_data,
	output logic              q_valid,
	input  logic              q_ready
);
	import sha1bs_pkg::*;

	logic  valid_s1;
	qent_t ent_s1;
	op_t   op_d;
	logic  keep;
	logic  take;

	assign msg.ready = !valid_s1 || q_ready;
	assign keep      = (msg.mode != MODE_UNUSED);
	assign take      = msg.valid && msg.ready && keep;

	always_comb begin
		unique case (msg.mode)
			MODE_DATA: op_d = OP_BYTE;
			MODE_LAST: op_d = OP_LAST_BYTE;
			default:   op_d = OP_END;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= '{op: op_d, data: msg.data_byte};
		end
	end

	assign q_valid = valid_s1;
	assign q_data  = ent_s1;
endmodule

/* rtl/sha1bs_fifo.sv */
// short op queue between front and back
// depends on sha1bs_pkg
module sha1bs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1bs_pkg::qent_t push_data,
	input  logic              push_valid,
	output logic              push_ready,
	output sha1bs_pkg::qent_t pop_data,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import sha1bs_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != QDEPTH[QAW:0]);
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

/* rtl/sha1bs_core.sv */
// compression core: 80 rounds one per cycle, then a fold into the chaining words
// depends on sha1bs_pkg
module sha1bs_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1bs_pkg::core_ctl_t ctl,
	input  sha1bs_pkg::block_t    blk,
	output logic                  busy,
	output sha1bs_pkg::hash_t     hash
);
	import sha1bs_pkg::*;

	hash_t       h_q;
	logic        busy_q;
	logic [6:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	block_t      w_q;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [31:0] t_sum;
	logic        fold;

	// round function and constant by round group
	always_comb begin
		if (rnd_q < RND_20) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = K0;
		end else if (rnd_q < RND_40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < RND_60) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	// sliding schedule window: w_q[0] is the word of the current round
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign fold  = (rnd_q == RND_FOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= IV;
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			if (ctl.init) begin
				h_q <= IV;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (fold) begin
					busy_q <= 1'b0;
					rnd_q  <= '0;
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			w_q <= blk;
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (busy_q && !fold) begin
			w_q <= {w_new, w_q[15:1]};
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign busy = busy_q;
	assign hash = h_q;
endmodule

/* rtl/sha1bs_back.sv */
// back part: packs bytes into the block, pads, sequences the core, holds the digest
// depends on sha1bs_pkg and sha1bs_out_if
module sha1bs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1bs_pkg::qent_t     q_data,
	input  logic                  q_valid,
	output logic                  q_ready,
	output sha1bs_pkg::core_ctl_t ctl,
	input  logic                  busy,
	input  sha1bs_pkg::hash_t     hash,
	output sha1bs_pkg::block_t    blk,
	sha1bs_out_if.source          digest
);
	import sha1bs_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_PAD,
		ST_LEN,
		ST_WAIT
	} state_t;

	state_t      state_q;
	logic        pend_q;
	logic [63:0] cnt_q;
	logic        out_valid_q;
	hash_t       out_q;
	block_t      blk_q;
	block_t      blk_d;
	logic [5:0]  pos;
	logic        pop;
	logic        is_byte;
	logic        start;
	logic        out_free;
	logic        finish;

	assign pos      = cnt_q[8:3];
	assign pop      = (state_q == ST_RUN) && q_valid && !pend_q;
	assign is_byte  = (q_data.op != OP_END);
	assign start    = pend_q && !busy;
	assign out_free = !out_valid_q || digest.ready;
	assign finish   = (state_q == ST_WAIT) && !pend_q && !busy && out_free;

	assign q_ready = pop;
	assign ctl     = '{start: start, init: finish};
	assign blk     = blk_q;

	// next block contents: byte lane write, padding, or length block
	always_comb begin
		blk_d = blk_q;
		case (state_q)
			ST_RUN: begin
				if (pop && is_byte) begin
					blk_d[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = q_data.data;
				end
			end
			ST_PAD: begin
				if (!pend_q) begin
					for (int w = 0; w < 16; w++) begin
						for (int l = 0; l < 4; l++) begin
							if (6'(4 * w + l) == pos) begin
								blk_d[w][8 * (3 - l) +: 8] = PAD_BYTE;
							end else if (6'(4 * w + l) > pos) begin
								blk_d[w][8 * (3 - l) +: 8] = 8'h00;
							end
						end
					end
					if (pos < LEN_POS) begin
						blk_d[14] = cnt_q[63:32];
						blk_d[15] = cnt_q[31:0];
					end
				end
			end
			ST_LEN: begin
				if (!pend_q) begin
					blk_d     = '0;
					blk_d[14] = cnt_q[63:32];
					blk_d[15] = cnt_q[31:0];
				end
			end
			default: begin
				blk_d = blk_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		blk_q <= blk_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (start) begin
				pend_q <= 1'b0;
			end
			// a new digest may load in the cycle the old one transfers
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (is_byte) begin
							cnt_q <= cnt_q + 64'd8;
							if (pos == LAST_POS) begin
								pend_q <= 1'b1;
							end
						end
						if (q_data.op != OP_BYTE) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!pend_q) begin
						pend_q  <= 1'b1;
						state_q <= (pos < LEN_POS) ? ST_WAIT : ST_LEN;
					end
				end
				ST_LEN: begin
					if (!pend_q) begin
						pend_q  <= 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (finish) begin
						out_q   <= hash;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign digest.valid        = out_valid_q;
	assign digest.digest_word0 = out_q[0];
	assign digest.digest_word1 = out_q[1];
	assign digest.digest_word2 = out_q[2];
	assign digest.digest_word3 = out_q[3];
	assign digest.digest_word4 = out_q[4];
endmodule

/* rtl/sha1_byte_stream_hash_unit.sv */
// top level of the sha-1 byte stream hash unit
// depends on sha1bs_pkg, sha1bs_if, sha1bs_front, sha1bs_fifo, sha1bs_core, sha1bs_back
//
//  channel  dir  transfer carries                      when
//  -------  ---  ------------------------------------  ------------------------------
//  msg      in   mode (2b), data_byte (8b)             valid && ready at rising clk
//  digest   out  digest_word0..digest_word4 (32b each)  valid && ready at rising clk
//
// a full 64-byte block is loaded into the core, run through 80 rounds and then
// folded into the chaining words; the back part gathers the next block while
// the core works, and long messages are limited by the single round unit
// end of message adds one padded block, or two when 56 or more bytes
// of the block are in use, plus the pad state and a load of the digest
// asynchronous active-low reset loads the initial chaining words and clears the
// count, queue and handshakes; no clearing pass is needed
// msg stalls only when the op queue is full; the back part stops taking ops while
// a full block waits for the core and while a message end is padded and hashed,
// which includes waiting for the output register to free
module sha1_byte_stream_hash_unit (
	input  logic         clk,
	input  logic         arst_n,
	sha1bs_in_if.sink    msg,
	sha1bs_out_if.source digest
);
	import sha1bs_pkg::*;

	// front to queue
	qent_t     fq_data;
	logic      fq_valid;
	logic      fq_ready;
	// queue to back
	qent_t     qb_data;
	logic      qb_valid;
	logic      qb_ready;
	// back to core
	core_ctl_t core_ctl;
	logic      core_busy;
	hash_t     core_hash;
	block_t    blk;

	// classify items, drop the unused mode
	sha1bs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.q_data  (fq_data),
		.q_valid (fq_valid),
		.q_ready (fq_ready)
	);

	// decouples input acceptance from block processing
	sha1bs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fq_data),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.pop_data   (qb_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready)
	);

	// block buffer, padding sequence and digest register
	sha1bs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (qb_data),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.ctl     (core_ctl),
		.busy    (core_busy),
		.hash    (core_hash),
		.blk     (blk),
		.digest  (digest)
	);

	// chaining words and the round engine
	sha1bs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.blk    (blk),
		.busy   (core_busy),
		.hash   (core_hash)
	);
endmodule

/* rtl/sha1bs_checker.sv */
// port-level checks of the sha-1 byte stream hash unit, bound to the top level
// depends on sha1bs_pkg and sha1_byte_stream_hash_unit
module sha1bs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word0,
	input logic [31:0] out_word1,
	input logic [31:0] out_word2,
	input logic [31:0] out_word3,
	input logic [31:0] out_word4
);
	import sha1bs_pkg::*;

	logic [3:0] fin_q;
	logic       fin_in;
	logic       fin_out;

	// messages ended at the input whose digest has not been transferred yet
	assign fin_in  = in_valid && in_ready && (in_mode == MODE_LAST || in_mode == MODE_END);
	assign fin_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0;
		end else begin
			case ({fin_in, fin_out})
				2'b10:   fin_q <= fin_q + 1'b1;
				2'b01:   fin_q <= fin_q - 1'b1;
				default: fin_q <= fin_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("digest valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word0) && $stable(out_word1) &&
			$stable(out_word2) && $stable(out_word3) && $stable(out_word4))
		else $error("digest changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fin_q != 4'd0)
		else $error("digest offered with no message ended");

	a_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q <= 4'd8)
		else $error("too many ended messages held inside");
endmodule

bind sha1_byte_stream_hash_unit sha1bs_checker u_sha1bs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_mode   (msg.mode),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_word0 (digest.digest_word0),
	.out_word1 (digest.digest_word1),
	.out_word2 (digest.digest_word2),
	.out_word3 (digest.digest_word3),
	.out_word4 (digest.digest_word4)
);

/* bench/sha1bs_tb_pkg.sv */
`timescale 1ns / 100ps
// digest tracker for the sha-1 byte stream hash unit bench
// keeps its own sha-1 state and the queue of digests still due; imports sha1bs_pkg
package sha1bs_tb_pkg;
	import sha1bs_pkg::*;

	class digest_tracker;
		logic [31:0] chain [5];
		logic [31:0] words [16];
		logic [63:0] bit_len;
		hash_t       digests_due [$];
		int          mismatches;

		function new();
			for (int i = 0; i < 16; i++)
				words[i] = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = 32'h67452301;
			chain[1] = 32'hEFCDAB89;
			chain[2] = 32'h98BADCFE;
			chain[3] = 32'h10325476;
			chain[4] = 32'hC3D2E1F0;
			bit_len  = '0;
		endfunction

		// big-endian byte lanes, first byte of a word clears it
		function void place_byte(int pos, logic [7:0] b);
			int wi;
			int lane;
			wi   = pos / 4;
			lane = pos % 4;
			if (lane == 0)
				words[wi] = '0;
			words[wi][(3 - lane) * 8 +: 8] = b;
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, e, f, k, x, sum;
			w = words;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < 80; t++) begin
				if (t >= 16) begin
					x = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
					w[t & 15] = {x[30:0], x[31]};
				end
				x = w[t & 15];
				if (t < 20) begin
					f = d ^ (b & (c ^ d));
					k = 32'h5A827999;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = 32'h6ED9EBA1;
				end else if (t < 60) begin
					f = (b & c) | (d & (b | c));
					k = 32'h8F1BBCDC;
				end else begin
					f = b ^ c ^ d;
					k = 32'hCA62C1D6;
				end
				sum = {a[26:0], a[31:27]} + f + e + k + x;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = sum;
			end
			chain[0] = chain[0] + a;
			chain[1] = chain[1] + b;
			chain[2] = chain[2] + c;
			chain[3] = chain[3] + d;
			chain[4] = chain[4] + e;
		endfunction

		function void absorb(logic [7:0] b);
			int pos;
			pos = int'(bit_len[8:3]);
			place_byte(pos, b);
			bit_len = bit_len + 64'd8;
			if (pos == 63)
				compress();
		endfunction

		// pad, append the length, and queue the digest
		function void close_message();
			int    pos;
			hash_t h;
			pos = int'(bit_len[8:3]);
			place_byte(pos, 8'h80);
			for (int p = pos + 1; p < 64; p++)
				place_byte(p, 8'h00);
			if (pos >= 56) begin
				compress();
				for (int i = 0; i < 16; i++)
					words[i] = '0;
			end
			words[14] = bit_len[63:32];
			words[15] = bit_len[31:0];
			compress();
			for (int i = 0; i < 5; i++)
				h[i] = chain[i];
			digests_due.push_back(h);
			restart();
		endfunction

		function void take_item(logic [1:0] mode, logic [7:0] b);
			case (mode)
				MODE_DATA: begin
					absorb(b);
				end
				MODE_LAST: begin
					absorb(b);
					close_message();
				end
				MODE_END: begin
					close_message();
				end
				default: begin
				end
			endcase
		endfunction

		function void match_digest(hash_t got);
			hash_t want;
			if (digests_due.size() == 0) begin
				$display("%0t unexpected digest: expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = digests_due.pop_front();
			for (int i = 0; i < 5; i++)
				if (want[i] !== got[i]) begin
					$display("%0t digest word %0d: expected %08h actual %08h",
						$time, i, want[i], got[i]);
					mismatches++;
				end
		endfunction

		function int pending();
			return digests_due.size();
		endfunction

		function bit clean();
			return (mismatches == 0) && (digests_due.size() == 0);
		endfunction
	endclass

endpackage

/* bench/testbench.sv */
`timescale 1ns / 100ps
// top of the sha-1 byte stream hash unit bench: clock, reset, drivers and monitor
// depends on sha1bs_pkg, sha1bs_if, sha1bs_tb_pkg and sha1_byte_stream_hash_unit
module testbench;
	import sha1bs_pkg::*;
	import sha1bs_tb_pkg::*;

	// cycles with no transfer on either channel before the run is called hung
	localparam int STALL_LIMIT  = 5000;
	// long output hold-off, enough for the op queue to fill behind it
	localparam int HOLD_CYCLES  = 400;
	// settle time after the last digest, about two padded blocks
	localparam int TAIL_CYCLES  = 200;
	localparam int RANDOM_ITEMS = 1900;

	logic clk = 1'b0;
	logic arst_n;

	sha1bs_in_if  msg ();
	sha1bs_out_if digest ();

	sha1_byte_stream_hash_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	digest_tracker tracker = new();

	// idle switches, redrawn per message so some stretches run gap-free
	bit src_idle = 1'b0;
	bit snk_idle = 1'b0;
	// request from the stimulus for one long output hold-off
	bit hold_req = 1'b0;
	// message items sent in the random part, ignored ones not counted
	int items_sent = 0;

	always #6 clk = ~clk;

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg.valid && msg.ready)
				tracker.take_item(msg.mode, msg.data_byte);
			if (digest.valid && digest.ready)
				tracker.match_digest({digest.digest_word4, digest.digest_word3,
					digest.digest_word2, digest.digest_word1, digest.digest_word0});
		end
	end

	// one transfer on msg; starts and returns at a falling edge with valid still high
	task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			msg.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg.valid     = 1'b1;
		msg.mode      = mode;
		msg.data_byte = b;
		do
			@(posedge clk);
		while (!msg.ready);
		@(negedge clk);
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	// a message of len bytes, closed either by a last byte or by a separate end
	// item, with an ignored mode now and then
	task automatic send_message(input int len);
		bit tail_byte;
		tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 24) == 0)
				send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
			if (tail_byte && i == len - 1)
				send_item(MODE_LAST, 8'($urandom_range(0, 255)));
			else
				send_item(MODE_DATA, 8'($urandom_range(0, 255)));
		end
		if (!tail_byte)
			send_item(MODE_END, 8'($urandom_range(0, 255)));
	endtask

	// pause the sender until every digest due has come out
	task automatic drain();
		msg.valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// mostly short messages; block edges often, so the long tail (56..63 bytes
	// in the last block) and exact 64-byte fills come up many times
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 11)
			return $urandom_range(0, 20);
		if (sel < 17) begin
			case ($urandom_range(0, 9))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 62;
				4: return 63;
				5: return 64;
				6: return 65;
				7: return 119;
				8: return 120;
				default: return 128;
			endcase
		end
		return $urandom_range(21, 200);
	endfunction

	// receiver: random gaps per digest, plus one long hold-off on request
	initial begin : digest_sink
		int gap;
		digest.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				digest.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = snk_idle ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				digest.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			digest.ready = 1'b1;
			do
				@(posedge clk);
			while (!(digest.valid || hold_req));
			@(negedge clk);
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((msg.valid && msg.ready) || (digest.valid && digest.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int msg_index;
		msg_index     = 0;
		msg.valid     = 1'b0;
		msg.mode      = MODE_DATA;
		msg.data_byte = 8'h00;
		arst_n        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty message, ignored mode alone, one-byte messages at the
		// byte extremes, the message abc, a short message with an ignored item inside
		// it, and two empty messages back to back
		send_item(MODE_END, 8'hFF);
		send_item(MODE_UNUSED, 8'hFF);
		send_item(MODE_UNUSED, 8'h00);
		send_item(MODE_LAST, 8'h00);
		send_item(MODE_LAST, 8'hFF);
		send_item(MODE_DATA, 8'h61);
		send_item(MODE_DATA, 8'h62);
		send_item(MODE_LAST, 8'h63);
		send_item(MODE_DATA, 8'h55);
		send_item(MODE_UNUSED, 8'hAA);
		send_item(MODE_DATA, 8'hAA);
		send_item(MODE_END, 8'h00);
		send_item(MODE_END, 8'h00);
		send_item(MODE_END, 8'hFF);
		drain();
		// the 64-bit count wrap needs 2^61 bytes and stays out of reach here

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			if (msg_index == 10) begin
				// receiver holds off while short messages keep coming, so the
				// output register, the back part and the op queue all back up
				hold_req = 1'b1;
				src_idle = 1'b0;
				repeat (8) send_item(MODE_LAST, 8'($urandom_range(0, 255)));
				drain();
			end else begin
				send_message(pick_length());
				if ($urandom_range(0, 15) == 0)
					drain();
			end
			msg_index++;
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.clean())
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sha1_byte_stream_hash_unit.f */
rtl/sha1bs_pkg.sv
rtl/sha1bs_if.sv
rtl/sha1bs_front.sv
rtl/sha1bs_fifo.sv
rtl/sha1bs_core.sv
rtl/sha1bs_back.sv
rtl/sha1_byte_stream_hash_unit.sv
rtl/sha1bs_checker.sv
bench/sha1bs_tb_pkg.sv
bench/testbench.sv
